>>> rtl/core/cbm_pkg.sv
package cbm_pkg;

  // result destinations
  typedef enum logic [2:0] {
    TGT_ROM    = 3'd0,
    TGT_LOGO   = 3'd1,
    TGT_ZERO   = 3'd2,
    TGT_SHARED = 3'd3,
    TGT_NONE   = 3'd4
  } target_t;

  // bus access kinds
  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  // detected console; code 3 is unused and acts as unknown
  typedef enum logic [1:0] {
    CONSOLE_UNKNOWN  = 2'd0,
    CONSOLE_ORIGINAL = 2'd1,
    CONSOLE_COLOUR   = 2'd2
  } console_t;

  localparam int ADDR_W       = 16;
  localparam int DATA_W       = 8;
  localparam int MEM_ADDR_W   = 19;
  localparam int ROM_OFFSET_W = 14;
  localparam int SHARED_OFF_W = 12;
  localparam int COUNT_W      = 8;

  // address map
  localparam logic [ADDR_W-1:0] ADDR_BANK_SEL  = 16'h2000;
  localparam logic [ADDR_W-1:0] ADDR_BANK_WIN  = 16'h4000;
  localparam logic [ADDR_W-1:0] ADDR_ROM_END   = 16'h8000;
  localparam logic [ADDR_W-1:0] ADDR_SHARED_LO = 16'hA000;
  localparam logic [ADDR_W-1:0] ADDR_SHARED_HI = 16'hAFFF;
  localparam logic [ADDR_W-1:0] ADDR_LOGO_LO   = 16'h0104;
  localparam logic [ADDR_W-1:0] ADDR_LOGO_HI   = 16'h0133;

  // logo count thresholds
  localparam logic [COUNT_W-1:0] ORIG_LOGO_LIMIT  = 8'd2;
  localparam logic [COUNT_W-1:0] COLOUR_LOGO_MARK = 8'd3;

  typedef struct packed {
    op_t               operation;
    logic [ADDR_W-1:0] bus_address;
    logic [DATA_W-1:0] bus_data;
  } access_t;

  typedef struct packed {
    target_t               target;
    logic [MEM_ADDR_W-1:0] mem_address;
    logic [DATA_W-1:0]     write_byte;
  } result_t;

endpackage

>>> rtl/core/cbm_access_if.sv
interface cbm_access_if;
  import cbm_pkg::*;

  logic              valid;
  logic              ready;
  op_t               operation;
  logic [ADDR_W-1:0] bus_address;
  logic [DATA_W-1:0] bus_data;

  modport source (output valid, operation, bus_address, bus_data, input ready);
  modport sink (input valid, operation, bus_address, bus_data, output ready);
endinterface

>>> rtl/core/cbm_result_if.sv
interface cbm_result_if;
  import cbm_pkg::*;

  logic                  valid;
  logic                  ready;
  target_t               target;
  logic [MEM_ADDR_W-1:0] mem_address;
  logic [DATA_W-1:0]     write_byte;

  modport source (output valid, target, mem_address, write_byte, input ready);
  modport sink (input valid, target, mem_address, write_byte, output ready);
endinterface

>>> rtl/core/cbm_cfg_if.sv
interface cbm_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> rtl/core/cbm_decode.sv
module cbm_decode #(
  parameter int SHARED_BYTES = 4096,
  parameter int BANK_BITS    = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  cbm_pkg::access_t  acc,
  input  cbm_pkg::console_t console_kind,
  output cbm_pkg::result_t  res
);
  import cbm_pkg::*;

  logic [BANK_BITS-1:0] bank;
  logic [BANK_BITS-1:0] bank_next;
  logic [COUNT_W-1:0]   count;
  logic [COUNT_W-1:0]   count_next;

  logic [ADDR_W-1:0]    addr;
  logic                 in_logo;
  logic [COUNT_W-1:0]   count_seen;
  logic [BANK_BITS-1:0] bank_sel;
  logic                 shared_fits;

  assign addr        = acc.bus_address;
  assign in_logo     = (addr >= ADDR_LOGO_LO) && (addr <= ADDR_LOGO_HI);
  assign bank_sel    = acc.bus_data[BANK_BITS-1:0];
  assign shared_fits = 32'(addr[SHARED_OFF_W-1:0]) < 32'(SHARED_BYTES);
  // a read at the logo start bumps the count before the console decision
  assign count_seen  = (acc.operation == OP_READ && addr == ADDR_LOGO_LO)
                       ? count + 8'd1 : count;

  // address decode and state update for one access
  always_comb begin
    res        = '{target: TGT_NONE, mem_address: '0, write_byte: '0};
    bank_next  = bank;
    count_next = count;
    if (acc.operation == OP_WRITE) begin
      if (addr >= ADDR_BANK_SEL && addr < ADDR_BANK_WIN) begin
        bank_next = (bank_sel == '0) ? BANK_BITS'(1) : bank_sel;
      end else if (addr >= ADDR_SHARED_LO && addr <= ADDR_SHARED_HI && shared_fits) begin
        res.target      = TGT_SHARED;
        res.mem_address = MEM_ADDR_W'(addr[SHARED_OFF_W-1:0]);
        res.write_byte  = acc.bus_data;
      end
    end else if (addr < ADDR_BANK_WIN) begin
      count_next      = count_seen;
      res.target      = TGT_ROM;
      res.mem_address = MEM_ADDR_W'(addr);
      case (console_kind)
        CONSOLE_ORIGINAL: begin
          if (count_seen < ORIG_LOGO_LIMIT && in_logo) begin
            res.target      = TGT_LOGO;
            res.mem_address = MEM_ADDR_W'(addr - ADDR_LOGO_LO);
          end
        end
        CONSOLE_COLOUR: begin
          if (count_seen == COLOUR_LOGO_MARK && in_logo) begin
            res.target      = TGT_LOGO;
            res.mem_address = MEM_ADDR_W'(addr - ADDR_LOGO_LO);
            if (addr == ADDR_LOGO_HI) begin
              count_next = count_seen + 8'd1;
            end
          end
        end
        default: ;
      endcase
    end else if (addr < ADDR_ROM_END) begin
      res.target      = TGT_ROM;
      res.mem_address = MEM_ADDR_W'({bank, addr[ROM_OFFSET_W-1:0]});
    end else begin
      res.target = TGT_ZERO;
    end
  end

  // mapper state
  always_ff @(posedge clk) begin
    if (rst) begin
      bank  <= '0;
      count <= '0;
    end else if (step) begin
      bank  <= bank_next;
      count <= count_next;
    end
  end

endmodule

>>> rtl/core/cartridge_bank_mapper.sv
// channel   dir  payload                                  transfer
// access    in   operation, bus_address, bus_data         valid & ready
// result    out  target, mem_address, write_byte          valid & ready
// cfg       in   data (console_kind)                      valid & ready
//
// one access per cycle while the result is not stalled; a result is valid once its
// access has passed the input register and been decoded into the result register
// rst is synchronous: clears bank number, logo count, console kind and valid flags
// a stalled result holds its register; the input register still takes one more access
module cartridge_bank_mapper #(
  parameter int SHARED_BYTES = 4096,
  parameter int BANK_BITS    = 5
) (
  input logic      clk,
  input logic      rst,
  cbm_access_if.sink   access,
  cbm_result_if.source result,
  cbm_cfg_if.sink      cfg
);
  import cbm_pkg::*;

  logic     in_vld;
  access_t  in_item;
  logic     out_vld;
  result_t  out_res;
  result_t  dec_res;
  console_t console_kind;
  logic     advance;
  logic     step;

  assign advance      = !out_vld || result.ready;
  assign step         = in_vld && advance;
  assign access.ready = !in_vld || advance;
  assign cfg.ready    = 1'b1;

  // console kind register
  always_ff @(posedge clk) begin
    if (rst) begin
      console_kind <= CONSOLE_UNKNOWN;
    end else if (cfg.valid) begin
      console_kind <= console_t'(cfg.data);
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (access.valid && access.ready) begin
      in_vld <= 1'b1;
    end else if (step) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (access.valid && access.ready) begin
      in_item <= '{operation: access.operation, bus_address: access.bus_address,
                   bus_data: access.bus_data};
    end
  end

  cbm_decode #(
    .SHARED_BYTES (SHARED_BYTES),
    .BANK_BITS    (BANK_BITS)
  ) u_decode (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .acc          (in_item),
    .console_kind (console_kind),
    .res          (dec_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= dec_res;
    end
  end

  assign result.valid       = out_vld;
  assign result.target      = out_res.target;
  assign result.mem_address = out_res.mem_address;
  assign result.write_byte  = out_res.write_byte;

endmodule
